>>> src/id_number_check_and_decode_top_defines.svh
// Assertion macros for the identification number check and decode block.
`ifndef ID_NUMBER_CHECK_AND_DECODE_TOP_DEFINES_SVH
`define ID_NUMBER_CHECK_AND_DECODE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDC_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/idc_pkg.sv
// Package with types, constants and tables for the identification number block.
package idc_pkg;

    localparam int ID_W       = 44;
    localparam int NUM_DIGITS = 13;
    localparam int DIG_IDX_W  = 4;
    localparam int NUM_LIMBS  = 7;
    localparam int NUM_CHUNKS = 6;
    localparam int CHUNK_W    = 8;
    localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
    localparam int COL_W      = 17;
    localparam int QUOT_W     = 11;
    localparam int SUM_W      = 11;
    localparam int CARRY_W    = 5;
    localparam int LIMB_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int STAGES     = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int CUTOFF_W   = 10;
    localparam int YEAR_W     = 12;
    localparam int Y3_W       = 10;
    localparam int SERIAL_W   = 10;
    localparam int WSUM_W     = 9;
    localparam int Q11_W      = 6;
    localparam int MDAY_W     = 5;

    localparam logic [ID_W-1:0]     ID_LIMIT       = 44'd10000000000000;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET   = 10'd17;
    localparam logic [YEAR_W-1:0]   EARLIEST_RESET = 12'd1918;

    // Reciprocal multipliers: floor(x / d) = (x * RECIP) >> SHIFT over the stated ranges.
    localparam int RECIP_COL         = 335545;
    localparam int RECIP_COL_W       = 19;
    localparam int RECIP_COL_SHIFT   = 25;
    localparam int RECIP_T           = 1311;
    localparam int RECIP_T_W         = 11;
    localparam int RECIP_T_SHIFT     = 17;
    localparam int RECIP_TEN         = 205;
    localparam int RECIP_TEN_W       = 8;
    localparam int RECIP_TEN_SHIFT   = 11;
    localparam int RECIP_ELEVEN      = 373;
    localparam int RECIP_ELEVEN_W    = 9;
    localparam int RECIP_ELEVEN_SHIFT = 12;

    localparam int TEN            = 10;
    localparam int ELEVEN         = 11;
    localparam int HUNDRED        = 100;
    localparam int FEMALE_SERIAL  = 500;
    localparam int YEAR_BASE_LOW  = 1000;
    localparam int YEAR_BASE_HIGH = 2000;
    localparam int MONTHS         = 12;
    localparam int FEBRUARY       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTURY_CUTOFF = 1'b0,
        CFG_EARLIEST_YEAR  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_VALID = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_CHECK = 2'd2,
        STATUS_DATE  = 2'd3
    } status_t;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [LIMB_W-1:0]  limb_t;

    // Base-100 limbs of 256 to the power of the chunk position, least significant limb first.
    localparam limb_t CHUNK_LIMB [NUM_CHUNKS][NUM_LIMBS] = '{
        '{7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd56, 7'd2,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd36, 7'd55, 7'd6,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd16, 7'd72, 7'd77, 7'd16, 7'd0,  7'd0, 7'd0},
        '{7'd96, 7'd72, 7'd96, 7'd94, 7'd42, 7'd0, 7'd0},
        '{7'd76, 7'd77, 7'd62, 7'd11, 7'd95, 7'd9, 7'd1}
    };

    localparam logic [2:0] CHECK_WEIGHT [NUM_DIGITS-1] = '{
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2
    };

    localparam logic [MDAY_W-1:0] MONTH_LEN [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

endpackage

>>> src/id_number_check_and_decode_top.sv
// Top level of the identification number check and decode block.
// Throughput: one number per cycle through seven pipeline stages; a stall on the result side
// only holds back full stages, so empty stages keep taking transfers.
// Reset: rst_n clears every stage valid flag and loads century_cutoff 17, earliest_year 1918.
`include "id_number_check_and_decode_top_defines.svh"

module id_number_check_and_decode_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            id_valid,
    output logic                            id_stall,
    input  logic [idc_pkg::ID_W-1:0]        id_value,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [1:0]                      status,
    output logic [6:0]                      birth_day,
    output logic [6:0]                      birth_month,
    output logic [11:0]                     birth_year,
    output logic [6:0]                      region_code,
    output logic [9:0]                      serial_number,
    output logic                            is_female,
    output logic [3:0]                      check_digit,
    input  logic                            cfg_we,
    input  logic [idc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [idc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import idc_pkg::*;

    logic [STAGES-1:0] ready;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-2:1] oor_reg;
    logic [STAGES-2:1] oor_next;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [CUTOFF_W-1:0] cutoff_next;
    logic [YEAR_W-1:0]   earliest_reg;
    logic [YEAR_W-1:0]   earliest_next;

    logic [ID_W-1:0]   v_reg;
    logic [ID_W-1:0]   v_next;
    logic [PAD_W-1:0]  v_pad;
    logic [COL_W-1:0]  col_reg   [NUM_LIMBS];
    logic [COL_W-1:0]  col_next  [NUM_LIMBS];
    logic [QUOT_W-1:0] quot_reg  [NUM_LIMBS];
    logic [QUOT_W-1:0] quot_next [NUM_LIMBS];
    limb_t             rem_reg   [NUM_LIMBS];
    limb_t             rem_next  [NUM_LIMBS];
    logic [CARRY_W-1:0] carry_reg  [NUM_LIMBS];
    logic [CARRY_W-1:0] carry_next [NUM_LIMBS];
    limb_t             part_reg  [NUM_LIMBS];
    limb_t             part_next [NUM_LIMBS];
    limb_t             limb_reg  [NUM_LIMBS];
    limb_t             limb_next [NUM_LIMBS];
    digit_t            digit_reg  [NUM_DIGITS];
    digit_t            digit_next [NUM_DIGITS];

    status_t             status_reg;
    status_t             status_next;
    limb_t               day_reg;
    limb_t               day_next;
    limb_t               month_reg;
    limb_t               month_next;
    logic [YEAR_W-1:0]   year_reg;
    logic [YEAR_W-1:0]   year_next;
    limb_t               region_reg;
    limb_t               region_next;
    logic [SERIAL_W-1:0] serial_reg;
    logic [SERIAL_W-1:0] serial_next;
    logic                female_reg;
    logic                female_next;
    digit_t              check_reg;
    digit_t              check_next;

    // A stage can load when it is empty or its content moves on in the same cycle.
    always_comb
    begin
        ready[STAGES-1] = !vld_reg[STAGES-1] || !res_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = ready[0] ? id_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = ready[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_comb
    begin
        cutoff_next   = cutoff_reg;
        earliest_next = earliest_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTURY_CUTOFF: cutoff_next   = cfg_wdata[CUTOFF_W-1:0];
                CFG_EARLIEST_YEAR:  earliest_next = cfg_wdata[YEAR_W-1:0];
                default:            cutoff_next   = cutoff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            cutoff_reg   <= CUTOFF_RESET;
            earliest_reg <= EARLIEST_RESET;
        end
        else
        begin
            vld_reg      <= vld_next;
            cutoff_reg   <= cutoff_next;
            earliest_reg <= earliest_next;
        end
    end

    // Stage 0: input register.
    assign v_next = id_value;
    assign v_pad  = PAD_W'(v_reg);

    // Stage 1: range check and base-100 column sums of the byte chunks.
    always_comb
    begin
        oor_next[1] = (v_reg >= ID_LIMIT);
        for (int i = 2; i < STAGES - 1; i++)
        begin
            oor_next[i] = oor_reg[i-1];
        end
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            col_next[k] = '0;
            for (int m = 0; m < NUM_CHUNKS; m++)
            begin
                col_next[k] = col_next[k]
                    + COL_W'(v_pad[m*CHUNK_W +: CHUNK_W]) * COL_W'(CHUNK_LIMB[m][k]);
            end
        end
    end

    // Stage 2: split each column into a limb remainder and a carry.
    always_comb
    begin
        logic [COL_W+RECIP_COL_W-1:0] prod;
        prod = '0;
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            prod = (COL_W+RECIP_COL_W)'(col_reg[k]) * (COL_W+RECIP_COL_W)'(RECIP_COL);
            quot_next[k] = prod[RECIP_COL_SHIFT +: QUOT_W];
            rem_next[k]  = LIMB_W'(col_reg[k] - COL_W'(quot_next[k]) * COL_W'(HUNDRED));
        end
    end

    // Stage 3: add the carries in and split once more.
    always_comb
    begin
        logic [SUM_W-1:0]           tsum;
        logic [SUM_W+RECIP_T_W-1:0] prod;
        tsum = '0;
        prod = '0;
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            tsum = SUM_W'(rem_reg[k])
                + ((k == 0) ? SUM_W'(0) : SUM_W'(quot_reg[(k == 0) ? 0 : k - 1]));
            prod = (SUM_W+RECIP_T_W)'(tsum) * (SUM_W+RECIP_T_W)'(RECIP_T);
            carry_next[k] = prod[RECIP_T_SHIFT +: CARRY_W];
            part_next[k]  = LIMB_W'(tsum - SUM_W'(carry_next[k]) * SUM_W'(HUNDRED));
        end
    end

    // Stage 4: final carry ripple; at most one unit moves between neighbouring limbs.
    always_comb
    begin
        limb_t sum_limb;
        logic  ripple;
        sum_limb = '0;
        ripple   = 1'b0;
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            sum_limb = part_reg[k] + LIMB_W'(ripple)
                + ((k == 0) ? LIMB_W'(0) : LIMB_W'(carry_reg[(k == 0) ? 0 : k - 1]));
            if (sum_limb >= LIMB_W'(HUNDRED))
            begin
                limb_next[k] = sum_limb - LIMB_W'(HUNDRED);
                ripple       = 1'b1;
            end
            else
            begin
                limb_next[k] = sum_limb;
                ripple       = 1'b0;
            end
        end
    end

    // Stage 5: decimal digits, two per limb (top limb: one), most significant at index 0.
    always_comb
    begin
        logic [LIMB_W+RECIP_TEN_W-1:0] prod;
        digit_t                        hi_dig;
        digit_t                        lo_dig;
        prod       = '0;
        hi_dig     = '0;
        lo_dig     = '0;
        digit_next = '{default: '0};
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            prod   = (LIMB_W+RECIP_TEN_W)'(limb_reg[k]) * (LIMB_W+RECIP_TEN_W)'(RECIP_TEN);
            hi_dig = prod[RECIP_TEN_SHIFT +: DIGIT_W];
            lo_dig = DIGIT_W'(limb_reg[k] - LIMB_W'(hi_dig) * LIMB_W'(TEN));
            digit_next[DIG_IDX_W'(NUM_DIGITS - 1 - 2 * k)] = lo_dig;
            if (2 * k + 2 <= NUM_DIGITS)
            begin
                digit_next[DIG_IDX_W'(NUM_DIGITS - 2 - 2 * k)] = hi_dig;
            end
        end
    end

    // Stage 6: check digit, field decode and date validation into the output register.
    always_comb
    begin
        logic [WSUM_W-1:0]                wsum;
        logic [WSUM_W+RECIP_ELEVEN_W-1:0] prod;
        logic [Q11_W-1:0]                 q11;
        digit_t                           rem11;
        digit_t                           chk;
        limb_t                            day;
        limb_t                            mon;
        logic [Y3_W-1:0]                  y3;
        logic                             high_century;
        logic [YEAR_W-1:0]                year;
        logic [1:0]                       mod4;
        logic                             cent;
        logic                             cent400;
        logic                             leap;
        logic                             month_ok;
        logic [3:0]                       mon_idx;
        logic [MDAY_W-1:0]                max_day;
        logic                             date_bad;

        wsum = '0;
        for (int i = 0; i < NUM_DIGITS - 1; i++)
        begin
            wsum = wsum + WSUM_W'(digit_reg[i]) * WSUM_W'(CHECK_WEIGHT[i]);
        end
        prod  = (WSUM_W+RECIP_ELEVEN_W)'(wsum) * (WSUM_W+RECIP_ELEVEN_W)'(RECIP_ELEVEN);
        q11   = prod[RECIP_ELEVEN_SHIFT +: Q11_W];
        rem11 = DIGIT_W'(wsum - WSUM_W'(q11) * WSUM_W'(ELEVEN));
        chk   = (rem11 == '0) ? '0 : DIGIT_W'(ELEVEN) - rem11;

        day = LIMB_W'(digit_reg[0]) * LIMB_W'(TEN) + LIMB_W'(digit_reg[1]);
        mon = LIMB_W'(digit_reg[2]) * LIMB_W'(TEN) + LIMB_W'(digit_reg[3]);
        y3  = Y3_W'(digit_reg[4]) * Y3_W'(HUNDRED) + Y3_W'(digit_reg[5]) * Y3_W'(TEN)
            + Y3_W'(digit_reg[6]);
        high_century = (y3 <= cutoff_reg);
        year = YEAR_W'(y3) + (high_century ? YEAR_W'(YEAR_BASE_HIGH) : YEAR_W'(YEAR_BASE_LOW));

        // Both century bases are multiples of 100, so the year's low digits decide.
        mod4    = 2'({digit_reg[5][0], 1'b0}) + digit_reg[6][1:0];
        cent    = (digit_reg[5] == '0) && (digit_reg[6] == '0);
        cent400 = high_century ? (digit_reg[4][1:0] == 2'd0) : (digit_reg[4][1:0] == 2'd2);
        leap    = ((mod4 == 2'd0) && !cent) || (cent && cent400);

        month_ok = (mon != '0) && (mon <= LIMB_W'(MONTHS));
        mon_idx  = month_ok ? 4'(mon - LIMB_W'(1)) : '0;
        max_day  = MONTH_LEN[mon_idx]
            + MDAY_W'(leap && (mon == LIMB_W'(FEBRUARY)));
        date_bad = (year < earliest_reg) || (day == '0) || !month_ok
            || (day > LIMB_W'(max_day));

        status_next = STATUS_VALID;
        day_next    = day;
        month_next  = mon;
        year_next   = year;
        region_next = LIMB_W'(digit_reg[7]) * LIMB_W'(TEN) + LIMB_W'(digit_reg[8]);
        serial_next = SERIAL_W'(digit_reg[9]) * SERIAL_W'(HUNDRED)
            + SERIAL_W'(digit_reg[10]) * SERIAL_W'(TEN) + SERIAL_W'(digit_reg[11]);
        female_next = (serial_next >= SERIAL_W'(FEMALE_SERIAL));
        check_next  = digit_reg[NUM_DIGITS-1];

        priority if (oor_reg[STAGES-2])
        begin
            status_next = STATUS_RANGE;
            day_next    = '0;
            month_next  = '0;
            year_next   = '0;
            region_next = '0;
            serial_next = '0;
            female_next = 1'b0;
            check_next  = '0;
        end
        else if (chk != digit_reg[NUM_DIGITS-1])
        begin
            status_next = STATUS_CHECK;
        end
        else if (date_bad)
        begin
            status_next = STATUS_DATE;
        end
        else
        begin
            status_next = STATUS_VALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            v_reg <= v_next;
        end
        for (int i = 1; i < STAGES - 1; i++)
        begin
            if (ready[i])
            begin
                oor_reg[i] <= oor_next[i];
            end
        end
        if (ready[1])
        begin
            col_reg <= col_next;
        end
        if (ready[2])
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        if (ready[3])
        begin
            carry_reg <= carry_next;
            part_reg  <= part_next;
        end
        if (ready[4])
        begin
            limb_reg <= limb_next;
        end
        if (ready[5])
        begin
            digit_reg <= digit_next;
        end
        if (ready[6])
        begin
            status_reg <= status_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            region_reg <= region_next;
            serial_reg <= serial_next;
            female_reg <= female_next;
            check_reg  <= check_next;
        end
    end

    assign id_stall      = !ready[0];
    assign res_valid     = vld_reg[STAGES-1];
    assign status        = status_reg;
    assign birth_day     = day_reg;
    assign birth_month   = month_reg;
    assign birth_year    = year_reg;
    assign region_code   = region_reg;
    assign serial_number = serial_reg;
    assign is_female     = female_reg;
    assign check_digit   = check_reg;

    `IDC_ASSERT_NOW(a_drained_accepts, clk, rst_n, !res_valid, !id_stall, "Input stalled while the result register is empty")
    `IDC_ASSERT_NEXT(a_no_spurious_item, clk, rst_n, !(|vld_reg) && !id_valid, !(|vld_reg), "Pipeline holds an item that was never transferred in")
    `IDC_ASSERT_NOW(a_range_fields_zero, clk, rst_n, res_valid && (status == STATUS_RANGE), (birth_day == '0) && (birth_month == '0) && (birth_year == '0) && (region_code == '0) && (serial_number == '0) && !is_female && (check_digit == '0), "Out of range result carries decoded fields")
    `IDC_ASSERT_NOW(a_valid_date_sane, clk, rst_n, res_valid && (status == STATUS_VALID), (birth_day != '0) && (birth_day <= 7'd31) && (birth_month != '0) && (birth_month <= 7'd12), "Valid result with an impossible day or month")

endmodule

>>> test/tb_top.sv
// Testbench for the ID number check and decode block: random handshakes, decodes checked by a local model.
module tb_top;
    import idc_pkg::*;

    localparam int NUM_DIRECTED     = 21;
    localparam int NUM_PHASES       = 5;
    localparam int RANDOM_PER_PHASE = 146;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_REPORTS      = 10;
    localparam int DRAIN_CYCLES     = 10;
    localparam int WEIGHTS [NUM_DIGITS-1] = '{7, 6, 5, 4, 3, 2, 7, 6, 5, 4, 3, 2};
    localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef digit_t digit_row_t [NUM_DIGITS];

    typedef struct packed {
        status_t     status;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [11:0] year;
        logic [6:0]  region;
        logic [9:0]  serial;
        logic        female;
        logic [3:0]  chk;
    } id_fields_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        id_fields_t      res;
    } id_decode_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        bit              typed;
        id_fields_t      res;
    } id_case_t;

    logic                  clk;
    logic                  rst_n;
    logic                  id_valid;
    logic                  id_stall;
    logic [ID_W-1:0]       id_value;
    logic                  res_valid;
    logic                  res_stall;
    logic [1:0]            status;
    logic [6:0]            birth_day;
    logic [6:0]            birth_month;
    logic [11:0]           birth_year;
    logic [6:0]            region_code;
    logic [9:0]            serial_number;
    logic                  is_female;
    logic [3:0]            check_digit;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic                  fixed_hit;
    id_fields_t            fixed_res;
    logic [CUTOFF_W-1:0]   cutoff_cfg;
    logic [YEAR_W-1:0]     earliest_cfg;
    id_decode_t            pending_decodes [$];
    id_case_t              dir_cases [NUM_DIRECTED];
    int                    bad_results = 0;
    int                    quiet_cycles = 0;
    int                    tx_calm = 0;
    int                    rx_calm = 0;

    id_number_check_and_decode_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .id_valid      (id_valid),
        .id_stall      (id_stall),
        .id_value      (id_value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .birth_day     (birth_day),
        .birth_month   (birth_month),
        .birth_year    (birth_year),
        .region_code   (region_code),
        .serial_number (serial_number),
        .is_female     (is_female),
        .check_digit   (check_digit),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned check_value(input digit_row_t dg);
        int unsigned total;
        total = 0;
        for (int i = 0; i < NUM_DIGITS - 1; i++)
        begin
            total += WEIGHTS[i] * dg[i];
        end
        total = 11 - total % 11;
        return (total == 11) ? 0 : total;
    endfunction

    function automatic int unsigned full_year(input int unsigned y3);
        return (y3 <= cutoff_cfg) ? y3 + 2000 : y3 + 1000;
    endfunction

    function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        return DAYS_PER_MONTH[(mon - 1) % 12] + ((mon == 2 && leap) ? 1 : 0);
    endfunction

    function automatic id_fields_t decode_id(input logic [ID_W-1:0] v);
        id_fields_t      r;
        digit_row_t      dg;
        logic [ID_W-1:0] rest;
        int unsigned     day_n;
        int unsigned     mon_n;
        int unsigned     yr;
        int unsigned     ser;
        r = '0;
        if (v >= ID_LIMIT)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        rest = v;
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            dg[i] = digit_t'(rest % 10);
            rest = rest / 10;
        end
        day_n = dg[0] * 10 + dg[1];
        mon_n = dg[2] * 10 + dg[3];
        yr    = full_year(dg[4] * 100 + dg[5] * 10 + dg[6]);
        ser   = dg[9] * 100 + dg[10] * 10 + dg[11];
        if (check_value(dg) != dg[12])
            r.status = STATUS_CHECK;
        else if (yr < earliest_cfg || day_n < 1 || mon_n < 1 || mon_n > 12 ||
                 day_n > month_days(mon_n, yr))
            r.status = STATUS_DATE;
        else
            r.status = STATUS_VALID;
        r.day    = 7'(day_n);
        r.month  = 7'(mon_n);
        r.year   = 12'(yr);
        r.region = 7'(dg[7] * 10 + dg[8]);
        r.serial = 10'(ser);
        r.female = (ser >= 500);
        r.chk    = dg[12];
        return r;
    endfunction

    // Builds a number with a matching check digit; the region is nudged while the check value is ten.
    function automatic logic [ID_W-1:0] make_id(input int unsigned day_n, input int unsigned mon_n,
                                                input int unsigned y3, input int unsigned region,
                                                input int unsigned serial);
        digit_row_t      dg;
        int unsigned     chk;
        logic [ID_W-1:0] v;
        chk = 10;
        while (chk == 10)
        begin
            dg = '{digit_t'(day_n / 10), digit_t'(day_n % 10), digit_t'(mon_n / 10),
                   digit_t'(mon_n % 10), digit_t'(y3 / 100), digit_t'((y3 / 10) % 10),
                   digit_t'(y3 % 10), digit_t'(region / 10), digit_t'(region % 10),
                   digit_t'(serial / 100), digit_t'((serial / 10) % 10), digit_t'(serial % 10),
                   digit_t'(0)};
            chk = check_value(dg);
            if (chk == 10)
                region = (region + 1) % 100;
        end
        v = '0;
        for (int i = 0; i < NUM_DIGITS - 1; i++)
        begin
            v = v * 10 + dg[i];
        end
        return v * 10 + chk;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int unsigned     kind;
        int unsigned     mon_n;
        int unsigned     day_n;
        int unsigned     y3;
        int unsigned     lim;
        logic [63:0]     wide;
        logic [ID_W-1:0] v;
        kind = $urandom_range(0, 19);
        wide = {$urandom, $urandom};
        if (kind < 15)
        begin
            mon_n = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: y3 = $urandom_range(0, 999);
                4, 5, 6:    y3 = $urandom_range(900, 999);
                7, 8:       y3 = $urandom_range(0, cutoff_cfg);
                default:    y3 = 100 * $urandom_range(0, 9);
            endcase
            lim = (mon_n >= 1 && mon_n <= 12) ? month_days(mon_n, full_year(y3)) : 31;
            case ($urandom_range(0, 9))
                7:       day_n = lim;
                8:       day_n = lim + 1;
                9:       day_n = $urandom_range(0, 99);
                default: day_n = $urandom_range(1, lim);
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                mon_n = 2;
                day_n = 29;
            end
            v = make_id(day_n, mon_n, y3, $urandom_range(0, 99), $urandom_range(0, 999));
            if (kind >= 13)
                v = v - v % 10 + (v % 10 + 1 + $urandom_range(0, 8)) % 10;
        end
        else if (kind < 17)
            v = ID_W'(wide % ID_LIMIT);
        else if (kind < 19)
            v = wide[ID_W-1:0];
        else if ($urandom_range(0, 1) != 0)
            v = ID_LIMIT + $urandom_range(0, 2);
        else
            v = ID_LIMIT - 1 - $urandom_range(0, 2);
        return v;
    endfunction

    function automatic id_case_t fixed_row(input logic [ID_W-1:0] v, input status_t st,
                                           input int d, input int m, input int y, input int rg,
                                           input int sn, input bit f, input int c);
        id_case_t row;
        row.id         = v;
        row.typed      = 1'b1;
        row.res.status = st;
        row.res.day    = 7'(d);
        row.res.month  = 7'(m);
        row.res.year   = 12'(y);
        row.res.region = 7'(rg);
        row.res.serial = 10'(sn);
        row.res.female = f;
        row.res.chk    = 4'(c);
        return row;
    endfunction

    function automatic id_case_t checked_row(input logic [ID_W-1:0] v);
        return '{id: v, typed: 1'b0, res: '0};
    endfunction

    function automatic string fields_str(input id_fields_t r);
        return $sformatf("status %0d day %0d month %0d year %0d region %0d serial %0d female %0d check %0d",
                         r.status, r.day, r.month, r.year, r.region, r.serial, r.female, r.chk);
    endfunction

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    task automatic drive_id(input logic [ID_W-1:0] v, input bit typed, input id_fields_t want);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            id_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        id_valid  <= 1'b1;
        id_value  <= v;
        fixed_hit <= typed;
        fixed_res <= want;
        do @(posedge clk); while (id_stall);
    endtask

    task automatic run_random(input int count);
        repeat (count) drive_id(pick_id(), 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_decodes.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_CENTURY_CUTOFF)
            cutoff_cfg = val[CUTOFF_W-1:0];
        else
            earliest_cfg = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int hold;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait(rx_calm);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    always @(posedge clk)
    begin
        id_fields_t got;
        id_decode_t want;
        bit         moved;
        moved = 1'b0;
        if (id_valid && !id_stall)
        begin
            want.id  = id_value;
            want.res = fixed_hit ? fixed_res : decode_id(id_value);
            pending_decodes.push_back(want);
            moved = 1'b1;
        end
        if (res_valid && !res_stall)
        begin
            moved      = 1'b1;
            got.status = status_t'(status);
            got.day    = birth_day;
            got.month  = birth_month;
            got.year   = birth_year;
            got.region = region_code;
            got.serial = serial_number;
            got.female = is_female;
            got.chk    = check_digit;
            if (pending_decodes.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("Unexpected result transfer: %s", fields_str(got));
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got !== want.res)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("Mismatch for id %0d: expected %s, got %s",
                                 want.id, fields_str(want.res), fields_str(got));
                end
            end
        end
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        id_valid     <= 1'b0;
        id_value     <= '0;
        fixed_hit    <= 1'b0;
        fixed_res    <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_CENTURY_CUTOFF;
        cfg_wdata    <= '0;
        cutoff_cfg   = CUTOFF_RESET;
        earliest_cfg = EARLIEST_RESET;
        dir_cases = '{
            fixed_row(44'd0, STATUS_DATE, 0, 0, 2000, 0, 0, 1'b0, 0),
            fixed_row(ID_LIMIT, STATUS_RANGE, 0, 0, 0, 0, 0, 1'b0, 0),
            fixed_row({ID_W{1'b1}}, STATUS_RANGE, 0, 0, 0, 0, 0, 1'b0, 0),
            fixed_row(ID_LIMIT - 1, STATUS_DATE, 99, 99, 1999, 99, 999, 1'b1, 9),
            fixed_row(44'd400, STATUS_CHECK, 0, 0, 2000, 0, 40, 1'b0, 0),
            checked_row(make_id(1, 1, 990, 71, 123)),
            checked_row(make_id(1, 1, 990, 71, 123) + 1),
            checked_row(make_id(29, 2, 0, 10, 500)),
            checked_row(make_id(29, 2, 900, 10, 499)),
            checked_row(make_id(29, 2, 996, 20, 0)),
            checked_row(make_id(31, 4, 980, 30, 1)),
            checked_row(make_id(30, 4, 980, 30, 2)),
            checked_row(make_id(1, 13, 980, 40, 3)),
            checked_row(make_id(1, 0, 980, 40, 4)),
            checked_row(make_id(0, 5, 980, 40, 5)),
            checked_row(make_id(31, 12, 999, 50, 999)),
            checked_row(make_id(1, 1, 917, 60, 6)),
            checked_row(make_id(1, 1, 918, 60, 7)),
            checked_row(make_id(31, 1, 17, 99, 8)),
            checked_row(make_id(1, 1, 18, 99, 9)),
            checked_row(make_id(99, 99, 999, 99, 999))
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_cases[i])
        begin
            drive_id(dir_cases[i].id, dir_cases[i].typed, dir_cases[i].res);
        end
        run_random(RANDOM_PER_PHASE);
        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            id_valid <= 1'b0;
            wait_drained();
            case (ph)
                1:
                begin
                    write_reg(CFG_CENTURY_CUTOFF, 12'd0);
                    write_reg(CFG_EARLIEST_YEAR, 12'd1000);
                end
                2:
                begin
                    write_reg(CFG_CENTURY_CUTOFF, 12'd999);
                    write_reg(CFG_EARLIEST_YEAR, 12'd2999);
                end
                default:
                begin
                    write_reg(CFG_CENTURY_CUTOFF, CFG_DATA_W'($urandom_range(0, 999)));
                    write_reg(CFG_EARLIEST_YEAR, CFG_DATA_W'($urandom_range(1000, 2999)));
                end
            endcase
            run_random(RANDOM_PER_PHASE);
        end
        id_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/idc_pkg.sv
src/id_number_check_and_decode_top.sv
test/tb_top.sv
